/* sv/tgpr_pkg.sv */
package tgpr_pkg;

   // Default build of the block.
   localparam int DEF_GLYPH_COUNT = 256;
   localparam int DEF_COORD_WIDTH = 16;

   // Glyph geometry.
   localparam int GLYPH_ROWS  = 8;
   localparam int GLYPH_BITS  = 8;
   localparam int ROW_IDX_W   = 3;
   localparam int PIX_IDX_W   = 6;
   localparam int CODE_BITS   = 8;

   // Cursor movement.
   localparam int CURSOR_RESET = 11;
   localparam int CURSOR_STEP  = 8;
   localparam int LINE_STEP    = 10;

   // Register port.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_FORE_COLOR  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BACK_COLOR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_BASE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_PITCH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WRAP_COLUMN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_MARGIN = 3'd5;

   localparam logic [31:0] FORE_COLOR_RESET  = 32'h0000_0000;
   localparam logic [31:0] BACK_COLOR_RESET  = 32'h00FF_FFFF;
   localparam logic [31:0] FRAME_BASE_RESET  = 32'h0000_0000;
   localparam logic [15:0] LINE_PITCH_RESET  = 16'd640;
   localparam logic [15:0] WRAP_COLUMN_RESET = 16'd626;
   localparam logic [15:0] LEFT_MARGIN_RESET = 16'd11;

   typedef struct packed {
      logic [31:0] fore_color;
      logic [31:0] back_color;
      logic [31:0] frame_base;
      logic [15:0] line_pitch;
      logic [15:0] wrap_column;
      logic [15:0] left_margin;
   } cfg_type;

endpackage

/* sv/tgpr_if.sv */
interface tgpr_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] char_code;
   logic [2:0] glyph_row;
   logic [7:0] row_bits;

   modport source (output valid, output kind, output char_code, output glyph_row,
                   output row_bits, input ready);
   modport sink   (input valid, input kind, input char_code, input glyph_row,
                   input row_bits, output ready);
endinterface

interface tgpr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_address;
   logic [31:0] pixel_color;
   logic        last_pixel;

   modport source (output valid, output pixel_address, output pixel_color,
                   output last_pixel, input ready);
   modport sink   (input valid, input pixel_address, input pixel_color,
                   input last_pixel, output ready);
endinterface

/* sv/tgpr_mem.sv */
module tgpr_mem #(
   parameter int WIDTH = tgpr_pkg::GLYPH_BITS,
   parameter int DEPTH = tgpr_pkg::DEF_GLYPH_COUNT * tgpr_pkg::GLYPH_ROWS
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* sv/tgpr_csr.sv */
module tgpr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [tgpr_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [tgpr_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [tgpr_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready,
   output tgpr_pkg::cfg_type                    cfg
);
   import tgpr_pkg::*;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic [CSR_IDX_W-1:0]  idx;
   logic                  wr_en;

   assign idx   = paddr[CSR_ADDR_W-1:2];
   assign wr_en = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_FORE_COLOR:  cfg_in.fore_color  = pwdata;
            REG_BACK_COLOR:  cfg_in.back_color  = pwdata;
            REG_FRAME_BASE:  cfg_in.frame_base  = pwdata;
            REG_LINE_PITCH:  cfg_in.line_pitch  = pwdata[15:0];
            REG_WRAP_COLUMN: cfg_in.wrap_column = pwdata[15:0];
            REG_LEFT_MARGIN: cfg_in.left_margin = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fore_color  <= FORE_COLOR_RESET;
         cfg_ff.back_color  <= BACK_COLOR_RESET;
         cfg_ff.frame_base  <= FRAME_BASE_RESET;
         cfg_ff.line_pitch  <= LINE_PITCH_RESET;
         cfg_ff.wrap_column <= WRAP_COLUMN_RESET;
         cfg_ff.left_margin <= LEFT_MARGIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_FORE_COLOR:  prdata = cfg_ff.fore_color;
         REG_BACK_COLOR:  prdata = cfg_ff.back_color;
         REG_FRAME_BASE:  prdata = cfg_ff.frame_base;
         REG_LINE_PITCH:  prdata = {16'd0, cfg_ff.line_pitch};
         REG_WRAP_COLUMN: prdata = {16'd0, cfg_ff.wrap_column};
         REG_LEFT_MARGIN: prdata = {16'd0, cfg_ff.left_margin};
         default:         prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* sv/text_glyph_pixel_renderer_core.sv */
// Store item: written into the glyph memory at the accept edge, no result.
// Draw item: after acceptance the sequencer passes through the setup state S_BASE
// to S_RUN, which registers the first of 64 pixels into the output and then one
// pixel per cycle unless the output stalls; no new item is taken before the last.
// The single pixel generator sets the throughput: one pixel per cycle unless stalled.
// Reset (synchronous, active high) restores the register defaults, puts the cursor
// at (11,11) and empties the output; the glyph memory is not cleared.
module text_glyph_pixel_renderer_core #(
   parameter int GLYPH_COUNT = tgpr_pkg::DEF_GLYPH_COUNT,
   parameter int COORD_WIDTH = tgpr_pkg::DEF_COORD_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   tgpr_req_if.sink                            req_chan,
   tgpr_rsp_if.source                          rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tgpr_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [tgpr_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [tgpr_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import tgpr_pkg::*;

   // Glyph memory geometry: one byte per glyph row, eight rows per character.
   localparam int CODE_W    = $clog2(GLYPH_COUNT);
   localparam int MEM_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
   localparam int MEM_AW    = CODE_W + ROW_IDX_W;

   // Sequencer states.
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_BASE = 2'd1;
   localparam logic [1:0] S_RUN  = 2'd2;

   cfg_type cfg;

   tgpr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // ------------------------------------------------------------------
   // Control and datapath registers.
   // ------------------------------------------------------------------
   logic [1:0]             state_ff, state_in;
   logic [COORD_WIDTH-1:0] cursor_x_ff, cursor_x_in;
   logic [COORD_WIDTH-1:0] cursor_y_ff, cursor_y_in;
   logic [CODE_W-1:0]      code_ff, code_in;
   logic                   hit_ff, hit_in;
   logic [31:0]            prod_ff, prod_in;
   logic [31:0]            line_ff, line_in;
   logic [GLYPH_BITS-1:0]  pat_ff, pat_in;
   logic [PIX_IDX_W-1:0]   pix_ff, pix_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_addr_ff, rsp_addr_in;
   logic [31:0]            rsp_color_ff, rsp_color_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Glyph memory ports.
   logic                   mem_we;
   logic [MEM_AW-1:0]      mem_waddr;
   logic                   mem_re;
   logic [MEM_AW-1:0]      mem_raddr;
   logic [GLYPH_BITS-1:0]  mem_rdata;

   tgpr_mem #(
      .WIDTH (GLYPH_BITS),
      .DEPTH (MEM_DEPTH)
   ) u_glyph_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (req_chan.row_bits),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // ------------------------------------------------------------------
   // Input side. The block takes an item only while idle; a store item is
   // written straight into the glyph memory, a draw item starts the
   // sequencer. Codes at or beyond the glyph count are outside the store:
   // their store items are dropped and their draws use an all-clear glyph.
   // ------------------------------------------------------------------
   logic req_fire;
   logic req_hit;
   logic adv;
   logic row_end;
   logic last_pix;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_hit        = ({1'b0, req_chan.char_code} < 9'(GLYPH_COUNT));

   assign mem_we    = req_fire && !req_chan.kind && req_hit;
   assign mem_waddr = {req_chan.char_code[CODE_W-1:0], req_chan.glyph_row};

   // In the run state a pixel is produced whenever the output register is free or is
   // being emptied in this cycle.
   assign adv      = (state_ff == S_RUN) && (!rsp_valid_ff || rsp_chan.ready);
   assign row_end  = (pix_ff[ROW_IDX_W-1:0] == 3'd7);
   assign last_pix = (pix_ff == 6'd63);

   // Read schedule of the glyph memory: row 0 at acceptance, row 1 in the
   // setup cycle, and row r+2 when the last pixel of row r leaves. The
   // read data is held by the memory until the next read, so each row's
   // byte sits ready by the time the row before it ends.
   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = {code_ff, 3'd0};
      case (state_ff)
         S_IDLE: begin
            mem_re    = req_fire && req_chan.kind && req_hit;
            mem_raddr = {req_chan.char_code[CODE_W-1:0], 3'd0};
         end
         S_BASE: begin
            mem_re    = hit_ff;
            mem_raddr = {code_ff, 3'd1};
         end
         S_RUN: begin
            mem_re    = adv && row_end && hit_ff;
            mem_raddr = {code_ff, pix_ff[PIX_IDX_W-1:ROW_IDX_W] + 3'd2};
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // Cursor update after the last pixel of a draw. Both coordinates
   // saturate at the top of their range.
   // ------------------------------------------------------------------
   logic [COORD_WIDTH-1:0] coord_max;
   logic [32:0]            x_plus;
   logic [32:0]            y_plus;
   logic [31:0]            margin_ext;
   logic [COORD_WIDTH-1:0] x_next;
   logic [COORD_WIDTH-1:0] y_next;
   logic                   wrap;

   assign coord_max  = '1;
   assign x_plus     = 33'(cursor_x_ff) + 33'(CURSOR_STEP);
   assign y_plus     = 33'(cursor_y_ff) + 33'(LINE_STEP);
   assign margin_ext = 32'(cfg.left_margin);
   assign wrap       = (x_plus >= 33'(cfg.wrap_column));

   always_comb begin
      if (wrap) begin
         x_next = margin_ext[COORD_WIDTH-1:0];
         y_next = (y_plus > 33'(coord_max)) ? coord_max : y_plus[COORD_WIDTH-1:0];
      end else begin
         x_next = (x_plus > 33'(coord_max)) ? coord_max : x_plus[COORD_WIDTH-1:0];
         y_next = cursor_y_ff;
      end
   end

   // ------------------------------------------------------------------
   // Pixel sequencer. At acceptance the row offset pitch*cursor_y is
   // multiplied into a register; the setup cycle adds base and cursor_x
   // to form the first row's start address. From then on the row start
   // grows by the pitch after each row and the pixel address is the row
   // start plus the column, all modulo 2^32.
   // ------------------------------------------------------------------
   logic [31:0] prod_full;

   assign prod_full = 32'(cfg.line_pitch) * 32'(cursor_y_ff);

   always_comb begin
      state_in    = state_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      code_in     = code_ff;
      hit_in      = hit_ff;
      prod_in     = prod_ff;
      line_in     = line_ff;
      pat_in      = pat_ff;
      pix_in      = pix_ff;

      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_chan.kind) begin
               code_in  = req_chan.char_code[CODE_W-1:0];
               hit_in   = req_hit;
               prod_in  = prod_full;
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            line_in  = cfg.frame_base + prod_ff + 32'(cursor_x_ff);
            pat_in   = hit_ff ? mem_rdata : '0;
            pix_in   = '0;
            state_in = S_RUN;
         end
         S_RUN: begin
            if (adv) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = line_ff + 32'(pix_ff[ROW_IDX_W-1:0]);
               rsp_color_in = pat_ff[GLYPH_BITS-1] ? cfg.fore_color : cfg.back_color;
               rsp_last_in  = last_pix;
               pix_in       = pix_ff + 6'd1;
               if (row_end) begin
                  line_in = line_ff + 32'(cfg.line_pitch);
                  pat_in  = hit_ff ? mem_rdata : '0;
               end else begin
                  pat_in  = {pat_ff[GLYPH_BITS-2:0], 1'b0};
               end
               if (last_pix) begin
                  cursor_x_in = x_next;
                  cursor_y_in = y_next;
                  state_in    = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cursor_x_ff  <= COORD_WIDTH'(CURSOR_RESET);
         cursor_y_ff  <= COORD_WIDTH'(CURSOR_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      code_ff      <= code_in;
      hit_ff       <= hit_in;
      prod_ff      <= prod_in;
      line_ff      <= line_in;
      pat_ff       <= pat_in;
      pix_ff       <= pix_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pixel_address = rsp_addr_ff;
   assign rsp_chan.pixel_color   = rsp_color_ff;
   assign rsp_chan.last_pixel    = rsp_last_ff;

endmodule
